// File: src/abfd_pkg.sv
// ----------------------------------------------------------------------------
// abfd_pkg
// Shared types, constants and half-bit helpers for the bi-phase frame decoder.
// ----------------------------------------------------------------------------
package abfd_pkg;

    localparam int unsigned INTERVAL_W        = 16;
    localparam int unsigned PATTERN_W         = 32;
    localparam int unsigned START_LEN_W       = 6;
    localparam int unsigned CFG_DATA_W        = 32;
    localparam int unsigned CFG_INDEX_W       = 3;
    localparam int unsigned FEEDBACK_W        = 8;

    localparam int unsigned MAX_START_LEN     = 32;
    localparam int unsigned PAYLOAD_HALF_BITS = 20;
    localparam int unsigned FRAME_BITS        = PAYLOAD_HALF_BITS / 2;

    // position runs up to MAX_START_LEN + PAYLOAD_HALF_BITS - 1
    localparam int unsigned POS_W     = $clog2(MAX_START_LEN + PAYLOAD_HALF_BITS);
    localparam int unsigned HB_IDX_W  = $clog2(PAYLOAD_HALF_BITS);
    localparam int unsigned PAT_IDX_W = $clog2(PATTERN_W);

    localparam logic [INTERVAL_W-1:0]  MIN_INTERVAL_RST   = 16'd3;
    localparam logic [INTERVAL_W-1:0]  SPLIT_INTERVAL_RST = 16'd9;
    localparam logic [INTERVAL_W-1:0]  MAX_INTERVAL_RST   = 16'd16;
    localparam logic [PATTERN_W-1:0]   START_PATTERN_RST  = 32'h0000_07FF;
    localparam logic [START_LEN_W-1:0] START_LENGTH_RST   = 6'd12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_INTERVAL   = 3'd0,
        CFG_SPLIT_INTERVAL = 3'd1,
        CFG_MAX_INTERVAL   = 3'd2,
        CFG_START_PATTERN  = 3'd3,
        CFG_START_LENGTH   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [POS_W-1:0]             pos;
        logic [PAYLOAD_HALF_BITS-1:0] half_bits;
        logic                         done;
    } push_res_t;

    typedef struct packed {
        logic                  ok;
        logic                  bad;
        logic                  sel;
        logic [FEEDBACK_W-1:0] feedback;
    } frame_res_t;

    // One half-bit: start matching first, then payload collection.
    function automatic push_res_t push_half_bit(
        input logic [POS_W-1:0]             pos,
        input logic [PAYLOAD_HALF_BITS-1:0] half_bits,
        input logic                         level,
        input logic [POS_W-1:0]             slen,
        input logic [PATTERN_W-1:0]         pattern
    );
        push_res_t        r;
        logic [POS_W-1:0] idx;
        r.pos       = pos;
        r.half_bits = half_bits;
        r.done      = 1'b0;
        idx         = pos - slen;
        if (pos < slen) begin
            if (pattern[pos[PAT_IDX_W-1:0]] == level)
                r.pos = pos + POS_W'(1);
            else
                r.pos = '0;
        end
        else if (idx >= POS_W'(PAYLOAD_HALF_BITS)) begin
            // start length shrank mid-frame: drop and restart
            r.pos = '0;
        end
        else begin
            r.half_bits[idx[HB_IDX_W-1:0]] = level;
            if (idx == POS_W'(PAYLOAD_HALF_BITS - 1)) begin
                r.pos  = '0;
                r.done = 1'b1;
            end
            else begin
                r.pos = pos + POS_W'(1);
            end
        end
        return r;
    endfunction

    // Cell boundary check, bit fold and even parity.
    function automatic frame_res_t decode_frame(
        input logic [PAYLOAD_HALF_BITS-1:0] half_bits
    );
        frame_res_t             r;
        logic                   boundary_ok;
        logic [FRAME_BITS-1:0]  bits;
        logic                   parity;
        boundary_ok = 1'b1;
        for (int i = 0; i < FRAME_BITS - 1; i++) begin
            if (half_bits[2*i+1] == half_bits[2*i+2])
                boundary_ok = 1'b0;
        end
        for (int i = 0; i < FRAME_BITS; i++) begin
            bits[i] = half_bits[2*i] ^ half_bits[2*i+1];
        end
        parity     = ^bits[FRAME_BITS-2:0];
        r.ok       = boundary_ok && (parity == bits[FRAME_BITS-1]);
        r.bad      = !r.ok;
        r.sel      = r.ok ? bits[0] : 1'b0;
        r.feedback = r.ok ? bits[FEEDBACK_W:1] : '0;
        return r;
    endfunction

endpackage

// File: src/ask_biphase_frame_decoder.sv
// ----------------------------------------------------------------------------
// ask_biphase_frame_decoder
// Turns line edge intervals into half-bits, matches the start pattern and
// decodes a 20 half-bit differential bi-phase payload with even parity.
// ----------------------------------------------------------------------------
// Pipeline: a request is captured in the input register when accepted, then
//   decoded into the result register when the output is not stalled.
// Throughput: one request per cycle unless stalled; half-bit logic is one pass.
// Reset: asynchronous, clears position, pipeline valids and loads the
//   register defaults; the payload half-bit store holds no reset value.
module ask_biphase_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [abfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [abfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // edge requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              line_level,
    input  logic [abfd_pkg::INTERVAL_W-1:0]   interval_samples,
    // results
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              frame_ok,
    output logic                              frame_bad,
    output logic                              power_select,
    output logic [abfd_pkg::FEEDBACK_W-1:0]   power_feedback
);
    import abfd_pkg::*;

    logic [INTERVAL_W-1:0]  min_interval_reg;
    logic [INTERVAL_W-1:0]  split_interval_reg;
    logic [INTERVAL_W-1:0]  max_interval_reg;
    logic [PATTERN_W-1:0]   start_pattern_reg;
    logic [START_LEN_W-1:0] start_length_reg;

    logic                   s1_valid_reg;
    logic                   s1_level_reg;
    logic [INTERVAL_W-1:0]  s1_dt_reg;

    logic [POS_W-1:0]             pos_reg;
    logic [POS_W-1:0]             pos_next;
    logic [PAYLOAD_HALF_BITS-1:0] half_bits_reg;
    logic [PAYLOAD_HALF_BITS-1:0] half_bits_next;

    logic                   out_valid_reg;
    frame_res_t             res_reg;
    frame_res_t             res_next;

    logic                   in_accept;
    logic                   advance;
    logic                   out_of_window;
    logic                   two_half_bits;
    logic [POS_W-1:0]       slen;
    push_res_t              push1;
    push_res_t              push2;
    frame_res_t             dec;
    logic                   frame_done;

    // ---------------- handshake ----------------
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg   <= MIN_INTERVAL_RST;
            split_interval_reg <= SPLIT_INTERVAL_RST;
            max_interval_reg   <= MAX_INTERVAL_RST;
            start_pattern_reg  <= START_PATTERN_RST;
            start_length_reg   <= START_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_INTERVAL:   min_interval_reg   <= cfg_wdata[INTERVAL_W-1:0];
                CFG_SPLIT_INTERVAL: split_interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                CFG_MAX_INTERVAL:   max_interval_reg   <= cfg_wdata[INTERVAL_W-1:0];
                CFG_START_PATTERN:  start_pattern_reg  <= cfg_wdata[PATTERN_W-1:0];
                CFG_START_LENGTH:   start_length_reg   <= cfg_wdata[START_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- half-bit logic ----------------
    assign slen = (start_length_reg > START_LEN_W'(MAX_START_LEN))
                ? POS_W'(MAX_START_LEN) : POS_W'(start_length_reg);

    assign out_of_window = (s1_dt_reg < min_interval_reg) || (s1_dt_reg > max_interval_reg);
    assign two_half_bits = (s1_dt_reg >= split_interval_reg);

    always_comb
    begin
        push1 = push_half_bit(pos_reg, half_bits_reg, s1_level_reg, slen,
                              start_pattern_reg);
        push2 = push_half_bit(push1.pos, push1.half_bits, s1_level_reg, slen,
                              start_pattern_reg);
        // at most one of the two pushes can close a frame
        frame_done = push1.done || (two_half_bits && push2.done);
        dec        = decode_frame(push1.done ? push1.half_bits : push2.half_bits);

        pos_next       = pos_reg;
        half_bits_next = half_bits_reg;
        res_next       = '0;
        priority if (s1_dt_reg == '0)
        begin
            pos_next = pos_reg;
        end
        else if (out_of_window)
        begin
            pos_next     = '0;
            res_next.bad = 1'b1;
        end
        else
        begin
            pos_next       = two_half_bits ? push2.pos : push1.pos;
            half_bits_next = two_half_bits ? push2.half_bits : push1.half_bits;
            if (frame_done)
                res_next = dec;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_level_reg <= line_level;
            s1_dt_reg    <= interval_samples;
        end
        if (advance)
        begin
            half_bits_reg <= half_bits_next;
            res_reg       <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_ok       = res_reg.ok;
    assign frame_bad      = res_reg.bad;
    assign power_select   = res_reg.sel;
    assign power_feedback = res_reg.feedback;

    // ---------------- assertions ----------------
    a_ok_bad_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.ok && res_reg.bad))
        else $error("frame_ok and frame_bad both set");

    a_fields_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.ok) |-> (res_reg.feedback == '0 && !res_reg.sel))
        else $error("decoded fields set without frame_ok");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(MAX_START_LEN + PAYLOAD_HALF_BITS))
        else $error("half-bit position out of range");

    a_window_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_dt_reg != '0 && out_of_window) |=> (pos_reg == '0 && res_reg.bad))
        else $error("out-of-window interval did not reset the frame");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(pos_reg)))
        else $error("state moved while result was stalled");

endmodule
